>>> hdl/spsd_pkg.sv
// spsd_pkg: shared constants, table and types for the powerset softmax decoder
// no dependencies; imported by softmax_powerset_speaker_decode_top and spsd_checker
`default_nettype none

package spsd_pkg;

  localparam int NumClasses  = 7;
  localparam int NumSpeakers = 3;
  localparam int LogpW       = 16;                 // signed Q5.10 log-probability
  localparam int ActW        = 16;                 // unsigned Q0.16 activity
  localparam int ProdW       = 33;                 // difference times log2(e)
  localparam int ExpW        = 17;                 // exponential, Q1.16, up to 65536
  localparam int SumW        = 19;                 // sum of seven exponentials
  localparam int RecipW      = 17;                 // floor(2^32 / sum)
  localparam int RemW        = 33;                 // divider remainder, starts at 2^32
  localparam int DivW        = SumW + RecipW;      // shifted divisor width
  localparam int ProbW       = 18;                 // (e * recip) >> 16
  localparam int GrpW        = 18;                 // sum of three probabilities
  localparam int NumStages   = 5 + RecipW + 1;     // front end, divider, multiply
  localparam int InDataW     = NumClasses * LogpW;
  localparam int OutDataW    = NumSpeakers * ActW;

  localparam logic [16:0] Log2eQ16 = 17'd94548;   // round(log2(e) * 2^16)
  localparam logic [6:0]  MaxShift = 7'd16;

  // classes that contain each speaker
  localparam int SpkClasses [NumSpeakers][3] = '{
    '{1, 4, 5},
    '{2, 4, 6},
    '{3, 5, 6}
  };

  typedef logic [NumClasses-1:1][ExpW-1:0] evec_t;

  // round(2^16 * 2^(-i/16)) for i = 0..16
  function automatic logic [ExpW-1:0] exp2_tab(input logic [4:0] idx);
    logic [ExpW-1:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/softmax_powerset_speaker_decode_top.sv
// softmax_powerset_speaker_decode_top: pipelined powerset softmax to per-speaker activity
// depends on spsd_pkg
`default_nettype none

// Takes one frame of seven signed Q5.10 class log-probabilities per transaction and
// returns the activity of speakers A, B and C as unsigned Q0.16. One frame is taken
// in every cycle while the output buffer has room. The pipeline is built around the
// 17-stage restoring divider that forms the reciprocal of the exponential sum, one
// quotient bit per stage, behind five stages of max, exponent and sum and one multiply
// stage. A two-entry output buffer keeps s_axis_tready registered; the pipeline holds
// still while the buffer is full.
module softmax_powerset_speaker_decode_top
  import spsd_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [InDataW-1:0]    s_axis_tdata,   // logp_0 .. logp_6, 16 bits each
  input  wire                  s_axis_tlast,   // last_frame
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // activity_a, activity_b, activity_c
  output logic                 m_axis_tlast    // frame_end
);

  logic en;
  logic in_acc;
  logic [NumStages-1:0] vld_q, lst_q;

  // stage 1: frame max
  logic signed [LogpW-1:0] x_in [NumClasses];
  logic signed [LogpW-1:0] mx_l1 [4];
  logic signed [LogpW-1:0] mx_l2 [2];
  logic signed [LogpW-1:0] mx_d;
  logic signed [LogpW-1:0] x_q [NumClasses];
  logic signed [LogpW-1:0] mx_q;

  // stage 2: base-2 exponent
  logic [LogpW-1:0] dif_d [NumClasses];
  logic [ProdW-1:0] y_d [NumClasses];
  logic [6:0]  n_q [NumClasses];
  logic [3:0]  idx_q [NumClasses];
  logic [11:0] r_q [NumClasses];

  // stage 3: table interpolation
  logic [ExpW-1:0] lo_d [NumClasses];
  logic [ExpW-1:0] hi_d [NumClasses];
  logic [ExpW-1:0] step_d [NumClasses];
  logic [23:0]     corr_d [NumClasses];
  logic [ExpW-1:0] hi_q [NumClasses];
  logic [11:0]     corr_q [NumClasses];
  logic [4:0]      sh_q [NumClasses];
  logic            zero_q [NumClasses];

  // stage 4: exponential
  logic [ExpW-1:0] m_d [NumClasses];
  logic [ExpW-1:0] e_q [NumClasses];

  // stage 5: sum
  logic [SumW-1:0] sum_d;
  logic [SumW-1:0] sum_q;
  evec_t           e5_q;

  // divider stages
  logic [RemW-1:0]   rem_q [RecipW];
  logic [SumW-1:0]   dv_q  [RecipW];
  logic [RecipW-1:0] quo_q [RecipW];
  evec_t             de_q  [RecipW];

  // multiply stage
  logic [ProbW-1:0] p_q [NumClasses];

  // output buffer
  logic [ActW-1:0]     act_d [NumSpeakers];
  logic [GrpW-1:0]     grp_d [NumSpeakers];
  logic [OutDataW-1:0] pipe_data;
  logic                pipe_push;
  logic                out_vld_q, skid_vld_q;
  logic [OutDataW-1:0] out_data_q, skid_data_q;
  logic                out_lst_q, skid_lst_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lst_q <= {lst_q[NumStages-2:0], s_axis_tlast};
    end
  end

  // stage 1
  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      x_in[c] = s_axis_tdata[c*LogpW +: LogpW];
    end
    for (int i = 0; i < 3; i++) begin
      mx_l1[i] = (x_in[2*i+1] > x_in[2*i]) ? x_in[2*i+1] : x_in[2*i];
    end
    mx_l1[3] = x_in[6];
    for (int i = 0; i < 2; i++) begin
      mx_l2[i] = (mx_l1[2*i+1] > mx_l1[2*i]) ? mx_l1[2*i+1] : mx_l1[2*i];
    end
    mx_d = (mx_l2[1] > mx_l2[0]) ? mx_l2[1] : mx_l2[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= x_in;
      mx_q <= mx_d;
    end
  end

  // stage 2: d = max - x, y = (d * log2e) >> 10
  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      dif_d[c] = LogpW'(mx_q - x_q[c]);
      y_d[c]   = ProdW'(dif_d[c]) * ProdW'(Log2eQ16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumClasses; c++) begin
        n_q[c]   <= y_d[c][32:26];
        idx_q[c] <= y_d[c][25:22];
        r_q[c]   <= y_d[c][21:10];
      end
    end
  end

  // stage 3: linear interpolation between table points
  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      hi_d[c]   = exp2_tab({1'b0, idx_q[c]});
      lo_d[c]   = exp2_tab(5'({1'b0, idx_q[c]} + 5'd1));
      step_d[c] = hi_d[c] - lo_d[c];
      corr_d[c] = step_d[c][11:0] * r_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumClasses; c++) begin
        hi_q[c]   <= hi_d[c];
        corr_q[c] <= corr_d[c][23:12];
        sh_q[c]   <= n_q[c][4:0];
        zero_q[c] <= n_q[c] > MaxShift;
      end
    end
  end

  // stage 4: mantissa shifted by the integer exponent
  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      m_d[c] = hi_q[c] - ExpW'(corr_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumClasses; c++) begin
        e_q[c] <= zero_q[c] ? '0 : (m_d[c] >> sh_q[c]);
      end
    end
  end

  // stage 5: sum of exponentials, never below 65536
  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NumClasses; c++) begin
      sum_d = sum_d + SumW'(e_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d;
      for (int c = 1; c < NumClasses; c++) begin
        e5_q[c] <= e_q[c];
      end
    end
  end

  // restoring division of 2^32 by the sum, msb of the quotient first
  for (genvar j = 0; j < RecipW; j++) begin : g_div
    localparam int K = RecipW - 1 - j;
    logic [RemW-1:0]   rem_in;
    logic [SumW-1:0]   dv_in;
    logic [RecipW-1:0] quo_in;
    evec_t             e_in;
    logic [DivW-1:0]   dsh;
    logic [DivW-1:0]   rem_x;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in = RemW'(1) << (RemW - 1);
      assign dv_in  = sum_q;
      assign quo_in = '0;
      assign e_in   = e5_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dv_in  = dv_q[j-1];
      assign quo_in = quo_q[j-1];
      assign e_in   = de_q[j-1];
    end

    assign dsh   = DivW'(dv_in) << K;
    assign rem_x = DivW'(rem_in);
    assign ge    = rem_x >= dsh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j]    <= ge ? RemW'(rem_x - dsh) : rem_in;
        quo_q[j]    <= quo_in | (RecipW'(ge) << K);
        dv_q[j]     <= dv_in;
        de_q[j]     <= e_in;
      end
    end
  end

  // probability per class, class 0 set to zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= '0;
      for (int c = 1; c < NumClasses; c++) begin
        p_q[c] <= ProbW'(((2*ExpW)'(de_q[RecipW-1][c]) * (2*ExpW)'(quo_q[RecipW-1])) >> 16);
      end
    end
  end

  // speaker groups with saturation
  always_comb begin
    for (int k = 0; k < NumSpeakers; k++) begin
      grp_d[k] = '0;
      for (int j = 0; j < 3; j++) begin
        grp_d[k] = grp_d[k] + GrpW'(p_q[SpkClasses[k][j]]);
      end
      act_d[k] = (grp_d[k] > GrpW'({ActW{1'b1}})) ? {ActW{1'b1}} : grp_d[k][ActW-1:0];
      pipe_data[k*ActW +: ActW] = act_d[k];
    end
  end

  assign pipe_push = en && vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !m_axis_tready) begin
      if (pipe_push) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= pipe_push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !m_axis_tready) begin
      if (pipe_push) begin
        skid_data_q <= pipe_data;
        skid_lst_q  <= lst_q[NumStages-1];
      end
    end else if (skid_vld_q) begin
      out_data_q <= skid_data_q;
      out_lst_q  <= skid_lst_q;
    end else begin
      out_data_q <= pipe_data;
      out_lst_q  <= lst_q[NumStages-1];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_lst_q;

endmodule

`default_nettype wire

>>> hdl/spsd_checker.sv
// spsd_checker: port-level assertions for the powerset softmax decoder, bound to its top
// depends on spsd_pkg and softmax_powerset_speaker_decode_top
`default_nettype none

module spsd_checker
  import spsd_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire [InDataW-1:0]    s_axis_tdata,
  input wire                  s_axis_tlast,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [OutDataW-1:0]   m_axis_tdata,
  input wire                  m_axis_tlast
);

  // a stalled transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // input backpressure only follows an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // a taken output frees the buffer at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready)
    else $error("input still stalled after output transaction");

  // an offered input transaction carries defined payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(s_axis_tdata) && !$isunknown(s_axis_tlast))
    else $error("input payload unknown while offered");

endmodule

bind softmax_powerset_speaker_decode_top spsd_checker u_spsd_checker (.*);

`default_nettype wire
